[src/pst_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pst_pkg
// Shared types and constants of the polyline stroke tessellator.
// ----------------------------------------------------------------------------
package pst_pkg;

  localparam int IDX_W    = 16;
  localparam int COORD_W  = 20;
  localparam int VERT_W   = 21;
  localparam int COLOR_W  = 32;
  localparam int THICK_W  = 12;
  localparam int UV_W     = 16;
  localparam int CFG_AW   = 2;
  localparam int CFG_DW   = 16;
  localparam int Q_DEPTH  = 4;
  localparam int Q_AW     = 2;
  localparam int NORM_ONE = 16384;

  localparam logic [CFG_AW-1:0] CFG_FRINGE  = 2'd0;
  localparam logic [CFG_AW-1:0] CFG_WHITE_U = 2'd1;
  localparam logic [CFG_AW-1:0] CFG_WHITE_V = 2'd2;

  localparam logic [7:0]         FRINGE_RESET = 8'd16;
  localparam logic [COLOR_W-1:0] RGB_MASK     = 32'h00FF_FFFF;

  localparam logic KIND_VERTEX = 1'b0;
  localparam logic KIND_INDEX  = 1'b1;

  // One stroke job: four vertices around point a, optionally 18 indices.
  typedef struct packed {
    logic [COORD_W-1:0] ax;
    logic [COORD_W-1:0] ay;
    logic [COORD_W-1:0] bx;
    logic [COORD_W-1:0] by;
    logic               reuse;
    logic [COLOR_W-1:0] color;
    logic [THICK_W-1:0] thick;
    logic               has_idx;
    logic [IDX_W-1:0]   b1;
    logic [IDX_W-1:0]   b2;
    logic               last;
  } job_t;

  typedef struct packed {
    logic push;
    logic pend;
  } front_stat_t;

  typedef struct packed {
    logic            full;
    logic            valid;
    logic [Q_AW:0]   count;
  } queue_stat_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIFF,
    ST_SQR,
    ST_SUM,
    ST_SQRT,
    ST_DIVI,
    ST_DIV,
    ST_NRM,
    ST_MUL,
    ST_RND,
    ST_EMIT_V,
    ST_EMIT_I
  } back_state_t;

  // Quad pattern: bits 1..0 offset within a point's group, bit 2 picks b2.
  function automatic logic [2:0] quad_pattern(input logic [4:0] i);
    logic [2:0] p;
    case (i)
      5'd0:  p = 3'd0;  5'd1:  p = 3'd1;  5'd2:  p = 3'd5;
      5'd3:  p = 3'd0;  5'd4:  p = 3'd5;  5'd5:  p = 3'd4;
      5'd6:  p = 3'd1;  5'd7:  p = 3'd2;  5'd8:  p = 3'd6;
      5'd9:  p = 3'd1;  5'd10: p = 3'd6;  5'd11: p = 3'd5;
      5'd12: p = 3'd2;  5'd13: p = 3'd3;  5'd14: p = 3'd7;
      5'd15: p = 3'd2;  5'd16: p = 3'd7;  5'd17: p = 3'd6;
      default: p = 3'd0;
    endcase
    return p;
  endfunction

endpackage

[src/pst_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pst_front
// Accepts path points, tracks path state and turns each point after a path's first into jobs.
// ----------------------------------------------------------------------------
module pst_front (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [pst_pkg::COORD_W-1:0]  in_point_x,
  input  logic [pst_pkg::COORD_W-1:0]  in_point_y,
  input  logic [pst_pkg::COLOR_W-1:0]  in_color,
  input  logic [pst_pkg::THICK_W-1:0]  in_thickness,
  input  logic                         in_closed,
  input  logic                         in_last_point,
  input  logic                         q_full,
  output logic                         q_push,
  output pst_pkg::job_t                q_wdata,
  output pst_pkg::front_stat_t         stat
);
  import pst_pkg::*;

  logic [COORD_W-1:0] first_x_r, first_y_r, prev_x_r, prev_y_r;
  logic               in_path_r;
  logic [IDX_W-1:0]   base_r, ctr_r;
  logic               pend_r;
  job_t               pend_job_r;
  job_t               job1, job2;
  logic               accept;

  assign in_stall = pend_r | q_full;
  assign accept   = in_valid & ~in_stall;

  always_comb begin
    job1.ax      = prev_x_r;
    job1.ay      = prev_y_r;
    job1.bx      = in_point_x;
    job1.by      = in_point_y;
    job1.reuse   = 1'b0;
    job1.color   = in_color;
    job1.thick   = in_thickness;
    job1.has_idx = 1'b1;
    job1.b1      = ctr_r;
    job1.b2      = ctr_r + IDX_W'(4);
    job1.last    = ~in_last_point;

    // Closing stroke of the last point; an open path keeps the last normal.
    job2.ax      = in_point_x;
    job2.ay      = in_point_y;
    job2.bx      = first_x_r;
    job2.by      = first_y_r;
    job2.reuse   = ~in_closed;
    job2.color   = in_color;
    job2.thick   = in_thickness;
    job2.has_idx = in_closed;
    job2.b1      = ctr_r + IDX_W'(4);
    job2.b2      = base_r;
    job2.last    = 1'b1;
  end

  assign q_push  = (pend_r & ~q_full) | (accept & in_path_r);
  assign q_wdata = pend_r ? pend_job_r : job1;
  assign stat.push = q_push;
  assign stat.pend = pend_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_x_r <= '0;
      first_y_r <= '0;
      prev_x_r  <= '0;
      prev_y_r  <= '0;
      in_path_r <= 1'b0;
      base_r    <= '0;
      ctr_r     <= '0;
      pend_r    <= 1'b0;
    end else begin
      if (pend_r && !q_full) begin
        pend_r <= 1'b0;
      end
      if (accept) begin
        if (!in_path_r) begin
          if (!in_last_point) begin
            first_x_r <= in_point_x;
            first_y_r <= in_point_y;
            prev_x_r  <= in_point_x;
            prev_y_r  <= in_point_y;
            base_r    <= ctr_r;
            in_path_r <= 1'b1;
          end
        end else begin
          prev_x_r <= in_point_x;
          prev_y_r <= in_point_y;
          if (in_last_point) begin
            ctr_r      <= ctr_r + IDX_W'(8);
            pend_r     <= 1'b1;
            pend_job_r <= job2;
            in_path_r  <= 1'b0;
          end else begin
            ctr_r <= ctr_r + IDX_W'(4);
          end
        end
      end
    end
  end

endmodule

[src/pst_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pst_queue
// Short job queue between the point front end and the stroke back end.
// ----------------------------------------------------------------------------
module pst_queue (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  pst_pkg::job_t         wdata,
  input  logic                  pop,
  output pst_pkg::job_t         rdata,
  output pst_pkg::queue_stat_t  stat
);
  import pst_pkg::*;

  job_t            mem_r [Q_DEPTH];
  logic [Q_AW-1:0] wr_r, rd_r;
  logic [Q_AW:0]   count_r;
  logic            do_push, do_pop;

  assign stat.count = count_r;
  assign stat.full  = (count_r == (Q_AW+1)'(Q_DEPTH));
  assign stat.valid = (count_r != '0);
  assign rdata      = mem_r[rd_r];
  assign do_push    = push & ~stat.full;
  assign do_pop     = pop & stat.valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r    <= '0;
      rd_r    <= '0;
      count_r <= '0;
    end else begin
      if (do_push) wr_r <= wr_r + Q_AW'(1);
      if (do_pop)  rd_r <= rd_r + Q_AW'(1);
      if (do_push && !do_pop) begin
        count_r <= count_r + (Q_AW+1)'(1);
      end else if (do_pop && !do_push) begin
        count_r <= count_r - (Q_AW+1)'(1);
      end
    end
  end

endmodule

[src/pst_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pst_back
// Computes the segment normal (or reuses the last one) with an iterative root
// and divide, then emits the four vertices and optional 18 indices of each job.
// ----------------------------------------------------------------------------
module pst_back (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic [pst_pkg::CFG_AW-1:0]   cfg_index,
  input  logic [pst_pkg::CFG_DW-1:0]   cfg_wdata,
  input  logic                         q_valid,
  input  pst_pkg::job_t                q_rdata,
  output logic                         q_pop,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic                         out_item_kind,
  output logic [pst_pkg::VERT_W-1:0]   out_vert_x,
  output logic [pst_pkg::VERT_W-1:0]   out_vert_y,
  output logic [pst_pkg::UV_W-1:0]     out_vert_u,
  output logic [pst_pkg::UV_W-1:0]     out_vert_v,
  output logic [pst_pkg::COLOR_W-1:0]  out_vert_color,
  output logic [pst_pkg::IDX_W-1:0]    out_index_value,
  output logic                         out_last_result
);
  import pst_pkg::*;

  back_state_t state_r, state_nxt;
  job_t        job_r;
  logic [7:0]      fringe_r;
  logic [UV_W-1:0] white_u_r, white_v_r;
  logic [4:0]      cnt_r;

  logic signed [VERT_W-1:0] dx_r, dy_r;
  logic [41:0] dxx_r, dyy_r;
  logic [41:0] sum;
  logic [63:0] rv_r, rr_r;
  logic [63:0] rbit, rtry;
  logic [46:0] remx_r, remy_r;
  logic [15:0] qx_r, qy_r;
  logic [47:0] dsh;
  logic signed [15:0] nx_r, ny_r;
  logic signed [30:0] pxo_r, pxh_r, pyo_r, pyh_r;
  logic signed [16:0] oxo_r, oxh_r, oyo_r, oyh_r;
  logic [13:0] w_out;
  logic [20:0] magx, magy;
  logic        ld_ok, emit;

  logic                 ov_r, okind_r, olast_r;
  logic [VERT_W-1:0]    ox_r, oy_r;
  logic [UV_W-1:0]      ou_r, ovv_r;
  logic [COLOR_W-1:0]   ocol_r;
  logic [IDX_W-1:0]     oidx_r;

  logic [VERT_W-1:0]    vx, vy;
  logic [COLOR_W-1:0]   vcol;
  logic [IDX_W-1:0]     idx;
  logic                 rlast;
  logic [2:0]           pat;
  logic signed [16:0]   offx, offy;
  logic signed [21:0]   sx, sy;

  function automatic logic signed [16:0] round_off(input logic signed [30:0] p);
    logic [30:0] mag;
    logic [15:0] r;
    mag = p[30] ? 31'(-p) : 31'(p);
    r   = 16'((mag + 31'd16384) >> 15);
    return p[30] ? -$signed({1'b0, r}) : $signed({1'b0, r});
  endfunction

  function automatic logic signed [15:0] finish(input logic [15:0] q, input logic neg);
    logic [15:0] c;
    c = (q > 16'(NORM_ONE)) ? 16'(NORM_ONE) : q;
    return neg ? -$signed(c) : $signed(c);
  endfunction

  assign ld_ok = ~ov_r | ~out_stall;
  assign sum   = dxx_r + dyy_r;
  assign rbit  = 64'd1 << (6'd62 - {cnt_r, 1'b0});
  assign rtry  = rr_r + rbit;
  assign dsh   = {16'd0, rr_r[31:0]} << (4'd15 - cnt_r[3:0]);
  assign w_out = {2'b00, job_r.thick} + {5'd0, fringe_r, 1'b0};
  assign magx  = dx_r[20] ? 21'(-dx_r) : 21'(dx_r);
  assign magy  = dy_r[20] ? 21'(-dy_r) : 21'(dy_r);

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:   if (q_valid) state_nxt = q_rdata.reuse ? ST_MUL : ST_DIFF;
      ST_DIFF:   state_nxt = ST_SQR;
      ST_SQR:    state_nxt = ST_SUM;
      ST_SUM:    state_nxt = (sum == '0) ? ST_MUL : ST_SQRT;
      ST_SQRT:   if (cnt_r == 5'd31) state_nxt = ST_DIVI;
      ST_DIVI:   state_nxt = ST_DIV;
      ST_DIV:    if (cnt_r[3:0] == 4'd15) state_nxt = ST_NRM;
      ST_NRM:    state_nxt = ST_MUL;
      ST_MUL:    state_nxt = ST_RND;
      ST_RND:    state_nxt = ST_EMIT_V;
      ST_EMIT_V: if (ld_ok && cnt_r == 5'd3) state_nxt = job_r.has_idx ? ST_EMIT_I : ST_IDLE;
      ST_EMIT_I: if (ld_ok && cnt_r == 5'd17) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // Control outputs.
  always_comb begin
    q_pop = 1'b0;
    emit  = 1'b0;
    unique case (state_r)
      ST_IDLE:              q_pop = q_valid;
      ST_EMIT_V, ST_EMIT_I: emit  = ld_ok;
      default: ;
    endcase
  end

  // Result payload for the current emit slot.
  always_comb begin
    pat  = quad_pattern(cnt_r);
    idx  = (pat[2] ? job_r.b2 : job_r.b1) + IDX_W'(pat[1:0]);
    offx = (cnt_r[1:0] == 2'd0 || cnt_r[1:0] == 2'd3) ? oxo_r : oxh_r;
    offy = (cnt_r[1:0] == 2'd0 || cnt_r[1:0] == 2'd3) ? oyo_r : oyh_r;
    if (cnt_r[1]) begin
      sx = $signed({{2{job_r.ax[19]}}, job_r.ax}) + 22'(offx);
      sy = $signed({{2{job_r.ay[19]}}, job_r.ay}) + 22'(offy);
    end else begin
      sx = $signed({{2{job_r.ax[19]}}, job_r.ax}) - 22'(offx);
      sy = $signed({{2{job_r.ay[19]}}, job_r.ay}) - 22'(offy);
    end
    vx   = sx[VERT_W-1:0];
    vy   = sy[VERT_W-1:0];
    vcol = (cnt_r[1:0] == 2'd0 || cnt_r[1:0] == 2'd3) ? (job_r.color & RGB_MASK)
                                                      : job_r.color;
    rlast = job_r.last &
            (((state_r == ST_EMIT_V) && cnt_r == 5'd3 && !job_r.has_idx) ||
             ((state_r == ST_EMIT_I) && cnt_r == 5'd17));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      fringe_r  <= FRINGE_RESET;
      white_u_r <= '0;
      white_v_r <= '0;
      ov_r      <= 1'b0;
      cnt_r     <= '0;
      nx_r      <= '0;
      ny_r      <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        case (cfg_index)
          CFG_FRINGE:  fringe_r  <= cfg_wdata[7:0];
          CFG_WHITE_U: white_u_r <= cfg_wdata;
          CFG_WHITE_V: white_v_r <= cfg_wdata;
          default: ;
        endcase
      end
      if (emit) begin
        ov_r <= 1'b1;
      end else if (!out_stall) begin
        ov_r <= 1'b0;
      end
      case (state_r)
        ST_SUM: begin
          cnt_r <= '0;
          if (sum == '0) begin
            nx_r <= '0;
            ny_r <= '0;
          end
        end
        ST_SQRT:   cnt_r <= cnt_r + 5'd1;
        ST_DIVI:   cnt_r <= '0;
        ST_DIV:    cnt_r <= cnt_r + 5'd1;
        ST_NRM: begin
          nx_r <= finish(qx_r, dy_r[20]);
          ny_r <= finish(qy_r, ~dx_r[20] & (dx_r != '0));
        end
        ST_RND:    cnt_r <= '0;
        ST_EMIT_V: if (ld_ok) cnt_r <= (cnt_r == 5'd3) ? 5'd0 : cnt_r + 5'd1;
        ST_EMIT_I: if (ld_ok) cnt_r <= (cnt_r == 5'd17) ? 5'd0 : cnt_r + 5'd1;
        default: ;
      endcase
    end
  end

  // Datapath registers without reset.
  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: if (q_valid) job_r <= q_rdata;
      ST_DIFF: begin
        dx_r <= $signed({job_r.bx[19], job_r.bx}) - $signed({job_r.ax[19], job_r.ax});
        dy_r <= $signed({job_r.by[19], job_r.by}) - $signed({job_r.ay[19], job_r.ay});
      end
      ST_SQR: begin
        dxx_r <= 42'(dx_r * dx_r);
        dyy_r <= 42'(dy_r * dy_r);
      end
      ST_SUM: begin
        rv_r <= {sum, 22'd0};
        rr_r <= '0;
      end
      ST_SQRT: begin
        if (rv_r >= rtry) begin
          rv_r <= rv_r - rtry;
          rr_r <= (rr_r >> 1) + rbit;
        end else begin
          rr_r <= rr_r >> 1;
        end
      end
      ST_DIVI: begin
        remx_r <= {1'b0, magy, 25'd0} + 47'(rr_r[31:1]);
        remy_r <= {1'b0, magx, 25'd0} + 47'(rr_r[31:1]);
        qx_r   <= '0;
        qy_r   <= '0;
      end
      ST_DIV: begin
        if ({1'b0, remx_r} >= dsh) begin
          remx_r <= 47'({1'b0, remx_r} - dsh);
          qx_r   <= {qx_r[14:0], 1'b1};
        end else begin
          qx_r   <= {qx_r[14:0], 1'b0};
        end
        if ({1'b0, remy_r} >= dsh) begin
          remy_r <= 47'({1'b0, remy_r} - dsh);
          qy_r   <= {qy_r[14:0], 1'b1};
        end else begin
          qy_r   <= {qy_r[14:0], 1'b0};
        end
      end
      ST_MUL: begin
        pxo_r <= nx_r * $signed({1'b0, w_out});
        pyo_r <= ny_r * $signed({1'b0, w_out});
        pxh_r <= nx_r * $signed({3'b000, job_r.thick});
        pyh_r <= ny_r * $signed({3'b000, job_r.thick});
      end
      ST_RND: begin
        oxo_r <= round_off(pxo_r);
        oyo_r <= round_off(pyo_r);
        oxh_r <= round_off(pxh_r);
        oyh_r <= round_off(pyh_r);
      end
      default: ;
    endcase
    if (emit) begin
      olast_r <= rlast;
      if (state_r == ST_EMIT_V) begin
        okind_r <= KIND_VERTEX;
        ox_r    <= vx;
        oy_r    <= vy;
        ou_r    <= white_u_r;
        ovv_r   <= white_v_r;
        ocol_r  <= vcol;
        oidx_r  <= '0;
      end else begin
        okind_r <= KIND_INDEX;
        ox_r    <= '0;
        oy_r    <= '0;
        ou_r    <= '0;
        ovv_r   <= '0;
        ocol_r  <= '0;
        oidx_r  <= idx;
      end
    end
  end

  assign out_valid       = ov_r;
  assign out_item_kind   = okind_r;
  assign out_vert_x      = ox_r;
  assign out_vert_y      = oy_r;
  assign out_vert_u      = ou_r;
  assign out_vert_v      = ovv_r;
  assign out_vert_color  = ocol_r;
  assign out_index_value = oidx_r;
  assign out_last_result = olast_r;

endmodule

[src/polyline_stroke_tessellator.sv]
`timescale 1ns / 1ps
// A segment job runs from the queue through DIFF, SQR, SUM, 32 root steps,
// DIVI, 16 divide steps, NRM, MUL and RND, then emits up to 22 output words.
// The back end works on one job at a time through its shared root and divide
// loop; an open path's last point reuses the previous normal and skips it.
// Reset (synchronous, rst_n low) clears path state, queue and output.
// ----------------------------------------------------------------------------
// polyline_stroke_tessellator
// Antialiased polyline stroke tessellator top level: front end, job queue,
// normal and emit back end.
// ----------------------------------------------------------------------------
module polyline_stroke_tessellator (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic [pst_pkg::CFG_AW-1:0]   cfg_index,
  input  logic [pst_pkg::CFG_DW-1:0]   cfg_wdata,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [pst_pkg::COORD_W-1:0]  in_point_x,
  input  logic [pst_pkg::COORD_W-1:0]  in_point_y,
  input  logic [pst_pkg::COLOR_W-1:0]  in_color,
  input  logic [pst_pkg::THICK_W-1:0]  in_thickness,
  input  logic                         in_closed,
  input  logic                         in_last_point,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic                         out_item_kind,
  output logic [pst_pkg::VERT_W-1:0]   out_vert_x,
  output logic [pst_pkg::VERT_W-1:0]   out_vert_y,
  output logic [pst_pkg::UV_W-1:0]     out_vert_u,
  output logic [pst_pkg::UV_W-1:0]     out_vert_v,
  output logic [pst_pkg::COLOR_W-1:0]  out_vert_color,
  output logic [pst_pkg::IDX_W-1:0]    out_index_value,
  output logic                         out_last_result
);
  import pst_pkg::*;

  job_t        q_wdata, q_rdata;
  logic        q_push, q_pop;
  front_stat_t fstat;
  queue_stat_t qstat;

  pst_front u_front (
    .clk, .rst_n, .in_valid, .in_stall, .in_point_x, .in_point_y, .in_color,
    .in_thickness, .in_closed, .in_last_point,
    .q_full(qstat.full), .q_push, .q_wdata, .stat(fstat)
  );

  pst_queue u_queue (
    .clk, .rst_n, .push(q_push), .wdata(q_wdata), .pop(q_pop),
    .rdata(q_rdata), .stat(qstat)
  );

  pst_back u_back (
    .clk, .rst_n, .cfg_we, .cfg_index, .cfg_wdata,
    .q_valid(qstat.valid), .q_rdata, .q_pop,
    .out_valid, .out_stall, .out_item_kind, .out_vert_x, .out_vert_y,
    .out_vert_u, .out_vert_v, .out_vert_color, .out_index_value, .out_last_result
  );

`ifndef SYNTHESIS
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    !(fstat.push && qstat.full))
    else $error("job pushed into a full queue");
  a_no_accept_pend: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |-> !fstat.pend)
    else $error("point accepted while a closing job is pending");
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> qstat.valid)
    else $error("back end popped an empty queue");
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    qstat.count <= (Q_AW+1)'(Q_DEPTH))
    else $error("queue count overflow");
`endif

endmodule
